FILE: hdl/brb_pkg.sv
// shared types and constants of the broadcast ring buffer
package brb_pkg;

  localparam int DEPTH       = 16;
  localparam int MAX_READERS = 8;
  localparam int DATA_WIDTH  = 32;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(MAX_READERS + 1);
  localparam int IDX_W  = 3;
  localparam int RC_W   = 4;
  localparam int STAT_W = 2;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [APB_AW-3:0] REG_READER_COUNT = '0;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_BADIDX  = 2'd2
  } brb_status_t;

  typedef enum logic [1:0] {
    K_WRITE = 2'd0,
    K_READ  = 2'd1,
    K_BAD   = 2'd2
  } brb_kind_t;

  typedef enum logic {
    B_EXEC = 1'b0,
    B_READ = 1'b1
  } brb_state_t;

  typedef struct packed {
    brb_kind_t              kind;
    logic [IDX_W-1:0]       idx;
    logic [DATA_WIDTH-1:0]  data;
  } brb_cmd_t;

  // slot index after p, wrapping at the ring depth
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

FILE: hdl/brb_ram.sv
// generic single-write, single-read ram with registered read data
module brb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/brb_front.sv
// request intake: classifies each beat and holds it in a short command queue
module brb_front import brb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic                  func,
  input  logic [IDX_W-1:0]      reader_index,
  input  logic [DATA_WIDTH-1:0] write_data,
  input  logic [CNT_W-1:0]      active,
  output brb_cmd_t              cmd,
  output logic                  cmd_valid,
  input  logic                  cmd_pop
);

  brb_cmd_t          q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;
  brb_cmd_t          incoming;

  assign req_stall = (count == QCNT_W'(QDEPTH));
  assign push      = req_valid && !req_stall;
  assign pop       = cmd_pop && (count != '0);
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];

  always_comb begin
    incoming.idx  = reader_index;
    incoming.data = write_data;
    if (!func) begin
      incoming.kind = K_WRITE;
    end else if ({{(CNT_W-IDX_W){1'b0}}, reader_index} >= active) begin
      incoming.kind = K_BAD;
    end else begin
      incoming.kind = K_READ;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: hdl/brb_back.sv
// execution unit: pointers, pending counts, slot ram and result register
module brb_back import brb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CNT_W-1:0]      active,
  input  brb_cmd_t              cmd,
  input  logic                  cmd_valid,
  output logic                  cmd_pop,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [STAT_W-1:0]     status,
  output logic [DATA_WIDTH-1:0] read_data,
  output logic [PTR_W-1:0]      slot
);

  brb_state_t            state;
  brb_state_t            state_next;
  logic [PTR_W-1:0]      wp;
  logic [PTR_W-1:0]      rp [MAX_READERS];
  logic [CNT_W-1:0]      pending [DEPTH];
  logic [PTR_W-1:0]      slot_hold;
  logic [PTR_W-1:0]      p;
  logic [CNT_W-1:0]      pend_p;
  logic                  out_free;
  logic                  do_write;
  logic                  do_read;
  logic                  load;
  brb_status_t           load_status;
  logic [DATA_WIDTH-1:0] load_data;
  logic [PTR_W-1:0]      load_slot;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // one pending-count lookup per command: write pointer or the reader's own
  assign p        = (cmd.kind == K_WRITE) ? wp : rp[cmd.idx];
  assign pend_p   = pending[p];
  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_EXEC;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd_pop     = 1'b0;
    do_write    = 1'b0;
    do_read     = 1'b0;
    load        = 1'b0;
    load_status = ST_REFUSED;
    load_data   = '0;
    load_slot   = '0;
    case (state)
      B_EXEC: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            K_WRITE: begin
              load = 1'b1;
              if (pend_p == '0) begin
                do_write    = 1'b1;
                load_status = ST_DONE;
                load_slot   = p;
              end
            end
            K_READ: begin
              if (pend_p != '0) begin
                do_read    = 1'b1;
                state_next = B_READ;
              end else begin
                load = 1'b1;
              end
            end
            default: begin
              load        = 1'b1;
              load_status = ST_BADIDX;
            end
          endcase
        end
      end
      B_READ: begin
        if (out_free) begin
          load        = 1'b1;
          load_status = ST_DONE;
          load_data   = ram_rdata;
          load_slot   = slot_hold;
          state_next  = B_EXEC;
        end
      end
      default: begin
        state_next = B_EXEC;
      end
    endcase
  end

  brb_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (p),
    .wdata (cmd.data),
    .re    (do_read),
    .raddr (p),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      for (int i = 0; i < MAX_READERS; i++) begin
        rp[i] <= '0;
      end
      for (int i = 0; i < DEPTH; i++) begin
        pending[i] <= '0;
      end
    end else begin
      if (do_write) begin
        pending[p] <= active;
        wp         <= next_slot(p);
      end
      if (do_read) begin
        pending[p]  <= pend_p - CNT_W'(1);
        rp[cmd.idx] <= next_slot(p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      slot_hold <= p;
    end
    if (load) begin
      status    <= load_status;
      read_data <= load_data;
      slot      <= load_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

FILE: hdl/broadcast_ring_buffer.sv
// broadcast ring buffer: every written word is read once by each active reader
// results: write, refusal and bad-index beats come from the result register, a
// successful read first passes the slot ram's registered read port
// throughput: one beat per cycle unless stalled; a successful read also holds
// the execution unit in B_READ; a 2-entry queue decouples intake from execution
// reset: pointers and pending counts cleared, reader_count 1, slot data undefined
module broadcast_ring_buffer import brb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic                  func,
  input  logic [IDX_W-1:0]      reader_index,
  input  logic [DATA_WIDTH-1:0] write_data,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [STAT_W-1:0]     status,
  output logic [DATA_WIDTH-1:0] read_data,
  output logic [PTR_W-1:0]      slot
);

  logic [RC_W-1:0]  reader_count;
  logic [CNT_W-1:0] active;
  logic             reg_hit;
  brb_cmd_t         cmd;
  logic             cmd_valid;
  logic             cmd_pop;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1:2] == REG_READER_COUNT);
  assign prdata  = reg_hit ? {{(APB_DW-RC_W){1'b0}}, reader_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      reader_count <= RC_W'(1);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      reader_count <= pwdata[RC_W-1:0];
    end
  end

  // count in use saturates at the reader limit
  assign active = (reader_count > RC_W'(MAX_READERS)) ? CNT_W'(MAX_READERS)
                                                      : CNT_W'(reader_count);

  brb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .func         (func),
    .reader_index (reader_index),
    .write_data   (write_data),
    .active       (active),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop)
  );

  brb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .active    (active),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .read_data (read_data),
    .slot      (slot)
  );

endmodule

FILE: test/brb_checker.sv
// request codes shared by the testbench, and the checker that predicts and compares replies
package brb_tb_pkg;

  localparam logic FN_WRITE = 1'b0;
  localparam logic FN_READ  = 1'b1;

endpackage

module brb_checker import brb_pkg::*, brb_tb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  logic                  func,
  input  logic [IDX_W-1:0]      reader_index,
  input  logic [DATA_WIDTH-1:0] write_data,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  logic [STAT_W-1:0]     status,
  input  logic [DATA_WIDTH-1:0] read_data,
  input  logic [PTR_W-1:0]      slot,
  output int                    mismatches,
  output int                    awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    brb_status_t           status;
    logic [DATA_WIDTH-1:0] word;
    logic [PTR_W-1:0]      slot;
  } reply_t;

  reply_t                due_replies[$];
  logic [DATA_WIDTH-1:0] ring_word [DEPTH];
  logic [CNT_W-1:0]      pending [DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr [MAX_READERS];
  logic [RC_W-1:0]       readers_cfg;

  // counts above the reader limit saturate
  function automatic logic [CNT_W-1:0] readers_in_use();
    return (readers_cfg > RC_W'(MAX_READERS)) ? CNT_W'(MAX_READERS) : CNT_W'(readers_cfg);
  endfunction

  function automatic logic [PTR_W-1:0] after(input logic [PTR_W-1:0] p);
    return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  task automatic ring_access(input logic f, input logic [IDX_W-1:0] idx,
                             input logic [DATA_WIDTH-1:0] d);
    reply_t          r;
    logic [PTR_W-1:0] p;
    r.status = ST_REFUSED;
    r.word   = '0;
    r.slot   = '0;
    if (f == FN_WRITE) begin
      p = wr_ptr;
      if (pending[p] == '0) begin
        ring_word[p] = d;
        pending[p]   = readers_in_use();
        wr_ptr       = after(p);
        r.status     = ST_DONE;
        r.slot       = p;
      end
    end else if (CNT_W'(idx) >= readers_in_use()) begin
      r.status = ST_BADIDX;
    end else begin
      p = rd_ptr[idx];
      if (pending[p] != '0) begin
        r.word      = ring_word[p];
        pending[p]  = pending[p] - 1'b1;
        rd_ptr[idx] = after(p);
        r.status    = ST_DONE;
        r.slot      = p;
      end
    end
    due_replies.push_back(r);
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      foreach (pending[i]) pending[i] = '0;
      foreach (rd_ptr[i]) rd_ptr[i] = '0;
      wr_ptr      = '0;
      readers_cfg = RC_W'(1);
      due_replies.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: reply beat with none due: status %0d data %h slot %0d",
                     $realtime, status, read_data, slot);
        end else begin
          want = due_replies.pop_front();
          if (status !== want.status || read_data !== want.word || slot !== want.slot) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected status %0d data %h slot %0d, got %0d %h %0d",
                       $realtime, want.status, want.word, want.slot,
                       status, read_data, slot);
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr[APB_AW-1:2] == REG_READER_COUNT)
        readers_cfg = pwdata[RC_W-1:0];
      if (req_valid && !req_stall)
        ring_access(func, reader_index, write_data);
    end
    awaiting = due_replies.size();
  end

endmodule

FILE: test/tb_top.sv
// top of the broadcast ring buffer testbench: clock, reset, stimulus and verdict
module tb_top import brb_pkg::*, brb_tb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_AW-1:0]     paddr = '0;
  logic [APB_DW-1:0]     pwdata = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic                  func = FN_WRITE;
  logic [IDX_W-1:0]      reader_index = '0;
  logic [DATA_WIDTH-1:0] write_data = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic [STAT_W-1:0]     status;
  logic [DATA_WIDTH-1:0] read_data;
  logic [PTR_W-1:0]      slot;
  logic                  calm = 1'b0;
  int                    mismatches;
  int                    awaiting;

  broadcast_ring_buffer dut (.*);

  brb_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) rsp_stall = !calm && ($urandom_range(99) < 11);

  initial begin
    #4_000_000;
    $display("broadcast_ring_buffer: mismatch");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_req(input logic f, input logic [IDX_W-1:0] idx,
                          input logic [DATA_WIDTH-1:0] d);
    while (!calm && $urandom_range(99) < 11) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid    = 1'b1;
    func         = f;
    reader_index = idx;
    write_data   = d;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    req_valid = 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_readers(input int value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {REG_READER_COUNT, 2'b00};
    pwdata  = APB_DW'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  initial begin
    int               phase_readers [12] = '{3, 8, 0, 15, 2, 9, 5, 1, 8, 12, 4, 7};
    int               n;
    int               wr_pct;
    logic [IDX_W-1:0] who;
    logic [DATA_WIDTH-1:0] word;

    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed: one reader after reset, empty ring, bad indexes, write/read back, then fill to full
    send_req(FN_READ, 3'd0, $urandom);
    send_req(FN_READ, 3'd1, $urandom);
    send_req(FN_READ, 3'd7, $urandom);
    send_req(FN_WRITE, 3'd5, 32'h0000_0000);
    send_req(FN_WRITE, 3'd2, 32'hFFFF_FFFF);
    send_req(FN_READ, 3'd0, 32'hFFFF_FFFF);
    send_req(FN_READ, 3'd0, 32'h0000_0000);
    send_req(FN_READ, 3'd0, $urandom);
    for (int i = 0; i < 16; i++)
      send_req(FN_WRITE, IDX_W'(i), 32'h1111_1111 * i);
    send_req(FN_WRITE, 3'd7, 32'hDEAD_BEEF);
    drain();

    foreach (phase_readers[ph]) begin
      set_readers(phase_readers[ph]);
      n      = (phase_readers[ph] > MAX_READERS) ? MAX_READERS : phase_readers[ph];
      wr_pct = (n == 0) ? 50 : 100 / (n + 1) + 10;
      calm   = (ph == 6);
      for (int i = 0; i < 128; i++) begin
        case ($urandom_range(9))
          0:       word = '0;
          1:       word = '1;
          default: word = $urandom;
        endcase
        if ($urandom_range(99) < wr_pct) begin
          send_req(FN_WRITE, IDX_W'($urandom_range(7)), word);
        end else begin
          // mostly live readers, a few indexes out of range
          if (n == 0 || $urandom_range(9) == 0) who = IDX_W'($urandom_range(7));
          else who = IDX_W'($urandom_range(n - 1));
          send_req(FN_READ, who, word);
        end
      end
      calm = 1'b0;
      drain();
    end

    if (mismatches == 0 && awaiting == 0) begin
      $display("broadcast_ring_buffer: match");
    end else begin
      $display("broadcast_ring_buffer: mismatch");
    end
    $finish;
  end

endmodule
